FILE: hw/rtl/mbv_pkg.sv
package mbv_pkg;

    localparam int VTX_W   = 12;
    localparam int NV      = 1 << VTX_W;
    localparam int EDGE_AW = 14;
    localparam int NE      = 1 << EDGE_AW;
    localparam int HELD_W  = EDGE_AW + 1;
    localparam int KEY_W   = 2 * VTX_W;
    localparam int CNT_W   = 8;
    localparam int CUR_W   = VTX_W + 1;
    localparam int ENTRY_W = KEY_W + 2;
    localparam int IN_W    = 4 * VTX_W;
    localparam int OUT_W   = 16;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_REGION = 3'd1,
        OP_TRI    = 3'd2,
        OP_QUAD   = 3'd3,
        OP_NEXT   = 3'd4
    } op_t;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OUTSIDE = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_NO_MORE = 3'd4;

    typedef enum logic [4:0] {
        S_CLR_RST, S_IDLE, S_DECODE, S_CLR, S_REGION, S_ELEM, S_REG_RD, S_REG_CK,
        S_KEYS, S_SEARCH, S_NEED, S_EDGE, S_EDGE_CK, S_VRD, S_VWR, S_SCAN_RD,
        S_SCAN_CK, S_OUT
    } state_t;

    typedef enum logic [4:0] {
        C_NONE, C_LOAD, C_CLR, C_REGION, C_ELEM, C_REG_RD, C_REG_CK, C_KEYS,
        C_SEARCH, C_NEED, C_EDGE, C_EDGE_CK, C_VRD, C_VWR, C_SCAN_RD, C_SCAN_CK,
        C_OUT
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       clr_last;
        logic       range_bad;
        logic       region_used;
        logic       region_hit;
        logic       last_corner;
        logic       search_done;
        logic       table_full;
        logic       key_found;
        logic       cnt_sat;
        logic       vstep;
        logic       scan_end;
        logic       scan_hit;
        logic       scan_phase;
        logic       out_free;
    } stat_t;

endpackage

FILE: hw/rtl/mbv_ctrl.sv
module mbv_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  mbv_pkg::stat_t st,
    output mbv_pkg::cmd_t  cmd,
    output logic           s_tready
);

    mbv_pkg::state_t state_reg;
    mbv_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbv_pkg::S_CLR_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = mbv_pkg::C_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            mbv_pkg::S_CLR_RST:
            begin
                cmd = mbv_pkg::C_CLR;
                if (st.clr_last)
                begin
                    state_next = mbv_pkg::S_IDLE;
                end
            end
            mbv_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd        = mbv_pkg::C_LOAD;
                    state_next = mbv_pkg::S_DECODE;
                end
            end
            mbv_pkg::S_DECODE:
            begin
                case (st.op)
                    mbv_pkg::OP_CLEAR:  state_next = mbv_pkg::S_CLR;
                    mbv_pkg::OP_REGION: state_next = mbv_pkg::S_REGION;
                    mbv_pkg::OP_TRI:    state_next = mbv_pkg::S_ELEM;
                    mbv_pkg::OP_QUAD:   state_next = mbv_pkg::S_ELEM;
                    mbv_pkg::OP_NEXT:   state_next = mbv_pkg::S_SCAN_RD;
                    default:            state_next = mbv_pkg::S_OUT;
                endcase
            end
            mbv_pkg::S_CLR:
            begin
                cmd = mbv_pkg::C_CLR;
                if (st.clr_last)
                begin
                    state_next = mbv_pkg::S_OUT;
                end
            end
            mbv_pkg::S_REGION:
            begin
                cmd        = mbv_pkg::C_REGION;
                state_next = mbv_pkg::S_OUT;
            end
            mbv_pkg::S_ELEM:
            begin
                cmd = mbv_pkg::C_ELEM;
                if (st.range_bad)
                begin
                    state_next = mbv_pkg::S_OUT;
                end
                else if (st.region_used)
                begin
                    state_next = mbv_pkg::S_REG_RD;
                end
                else
                begin
                    state_next = mbv_pkg::S_KEYS;
                end
            end
            mbv_pkg::S_REG_RD:
            begin
                cmd        = mbv_pkg::C_REG_RD;
                state_next = mbv_pkg::S_REG_CK;
            end
            mbv_pkg::S_REG_CK:
            begin
                cmd = mbv_pkg::C_REG_CK;
                if (!st.region_hit)
                begin
                    state_next = mbv_pkg::S_OUT;
                end
                else if (st.last_corner)
                begin
                    state_next = mbv_pkg::S_KEYS;
                end
                else
                begin
                    state_next = mbv_pkg::S_REG_RD;
                end
            end
            mbv_pkg::S_KEYS:
            begin
                cmd        = mbv_pkg::C_KEYS;
                state_next = mbv_pkg::S_SEARCH;
            end
            mbv_pkg::S_SEARCH:
            begin
                cmd = mbv_pkg::C_SEARCH;
                if (st.search_done)
                begin
                    state_next = mbv_pkg::S_NEED;
                end
            end
            mbv_pkg::S_NEED:
            begin
                cmd        = mbv_pkg::C_NEED;
                state_next = st.table_full ? mbv_pkg::S_OUT : mbv_pkg::S_EDGE;
            end
            mbv_pkg::S_EDGE:
            begin
                cmd        = mbv_pkg::C_EDGE;
                state_next = st.key_found ? mbv_pkg::S_EDGE_CK : mbv_pkg::S_VRD;
            end
            mbv_pkg::S_EDGE_CK:
            begin
                cmd = mbv_pkg::C_EDGE_CK;
                if (!st.cnt_sat)
                begin
                    state_next = mbv_pkg::S_VRD;
                end
                else if (st.last_corner)
                begin
                    state_next = mbv_pkg::S_OUT;
                end
                else
                begin
                    state_next = mbv_pkg::S_EDGE;
                end
            end
            mbv_pkg::S_VRD:
            begin
                cmd        = mbv_pkg::C_VRD;
                state_next = mbv_pkg::S_VWR;
            end
            mbv_pkg::S_VWR:
            begin
                cmd = mbv_pkg::C_VWR;
                if (!st.vstep)
                begin
                    state_next = mbv_pkg::S_VRD;
                end
                else if (st.last_corner)
                begin
                    state_next = mbv_pkg::S_OUT;
                end
                else
                begin
                    state_next = mbv_pkg::S_EDGE;
                end
            end
            mbv_pkg::S_SCAN_RD:
            begin
                cmd        = mbv_pkg::C_SCAN_RD;
                state_next = st.scan_end ? mbv_pkg::S_OUT : mbv_pkg::S_SCAN_CK;
            end
            mbv_pkg::S_SCAN_CK:
            begin
                cmd = mbv_pkg::C_SCAN_CK;
                if (st.scan_phase && st.scan_hit)
                begin
                    state_next = mbv_pkg::S_OUT;
                end
                else
                begin
                    state_next = mbv_pkg::S_SCAN_RD;
                end
            end
            mbv_pkg::S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd        = mbv_pkg::C_OUT;
                    state_next = mbv_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mbv_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/mbv_datapath.sv
module mbv_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mbv_pkg::cmd_t             cmd,
    input  logic [mbv_pkg::IN_W-1:0]  s_tdata,
    input  logic [2:0]                s_tuser,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [mbv_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tlast,
    output mbv_pkg::stat_t            st
);

    localparam int VW = mbv_pkg::VTX_W;
    localparam int EW = mbv_pkg::EDGE_AW;
    localparam int HW = mbv_pkg::HELD_W;
    localparam int KW = mbv_pkg::KEY_W;
    localparam int CW = mbv_pkg::CNT_W;
    localparam int UW = mbv_pkg::CUR_W;

    // memories
    logic                        region_mem [mbv_pkg::NV];
    logic [mbv_pkg::ENTRY_W-1:0] edge_mem   [mbv_pkg::NE];
    logic [CW-1:0]               vtx_mem    [mbv_pkg::NV];

    // control state
    logic [HW-1:0] held_reg;
    logic          used_reg;
    logic [UW-1:0] cursor_reg;
    logic [VW-1:0] sweep_reg;
    logic          ovalid_reg;

    // payload
    logic [2:0]    op_reg;
    logic [VW-1:0] corner_reg [4];
    logic [KW-1:0] key_reg    [4];
    logic [3:0]    found_reg;
    logic [EW-1:0] idx_reg    [4];
    logic [1:0]    i_reg;
    logic          vstep_reg;
    logic          up_reg;
    logic [HW-1:0] ptr_reg;
    logic          rdv_reg;
    logic [EW-1:0] rdi_reg;
    logic [UW-1:0] scan_reg;
    logic          phase_reg;
    logic [2:0]    res_st_reg;
    logic [VW-1:0] res_v_reg;
    logic          res_f_reg;
    logic          res_l_reg;
    logic [2:0]    ost_reg;
    logic [VW-1:0] overt_reg;
    logic          ofound_reg;
    logic          olast_reg;
    logic                        region_rd_reg;
    logic [mbv_pkg::ENTRY_W-1:0] edge_rd_reg;
    logic [CW-1:0]               vtx_rd_reg;

    logic [1:0]    n_last;
    logic [KW-1:0] cur_key;
    logic [VW-1:0] vaddr;
    logic [CW-1:0] vnew;
    logic [KW-1:0] key_calc [4];
    logic [3:0]    need_bit;
    logic [2:0]    need;
    logic          range_bad;
    logic          table_full;
    logic [1:0]    cnt;
    logic          search_done;
    logic          out_free;
    logic [EW-1:0] edge_raddr;
    logic [VW-1:0] vtx_raddr;

    assign n_last   = (op_reg == mbv_pkg::OP_QUAD) ? 2'd3 : 2'd2;
    assign cur_key  = key_reg[i_reg];
    assign vaddr    = vstep_reg ? cur_key[VW-1:0] : cur_key[KW-1:VW];
    assign cnt      = edge_rd_reg[1:0];
    assign out_free = !ovalid_reg || m_tready;
    assign search_done = (ptr_reg >= held_reg) && !rdv_reg;

    always_comb
    begin
        if (up_reg)
        begin
            vnew = (vtx_rd_reg != {CW{1'b1}}) ? vtx_rd_reg + 1'b1 : vtx_rd_reg;
        end
        else
        begin
            vnew = (vtx_rd_reg != {CW{1'b1}} && vtx_rd_reg != '0) ?
                   vtx_rd_reg - 1'b1 : vtx_rd_reg;
        end
    end

    always_comb
    begin
        range_bad = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if ((2'(k) <= n_last || op_reg == mbv_pkg::OP_REGION) &&
                ({1'b0, corner_reg[k]} >= UW'(mbv_pkg::NV)) &&
                (k == 0 || op_reg != mbv_pkg::OP_REGION))
            begin
                range_bad = 1'b1;
            end
        end
    end

    // edge keys, smaller endpoint in the upper half
    always_comb
    begin
        logic [VW-1:0] p;
        logic [VW-1:0] q;
        logic [1:0]    nk;
        for (int k = 0; k < 4; k++)
        begin
            nk = (2'(k) == n_last) ? 2'd0 : 2'(k + 1);
            p  = corner_reg[k];
            q  = corner_reg[nk];
            key_calc[k] = (p < q) ? {p, q} : {q, p};
        end
    end

    // distinct keys that are not yet in the table
    always_comb
    begin
        logic dup;
        need = '0;
        for (int k = 0; k < 4; k++)
        begin
            dup = 1'b0;
            for (int j = 0; j < k; j++)
            begin
                if (key_reg[j] == key_reg[k])
                begin
                    dup = 1'b1;
                end
            end
            need_bit[k] = (2'(k) <= n_last) && !found_reg[k] && !dup;
            need = need + {2'b00, need_bit[k]};
        end
    end

    assign table_full = ({1'b0, held_reg} + (HW+1)'(need)) > (HW+1)'(mbv_pkg::NE);

    assign edge_raddr = (cmd == mbv_pkg::C_SEARCH) ? ptr_reg[EW-1:0] : idx_reg[i_reg];
    assign vtx_raddr  = (cmd == mbv_pkg::C_SCAN_RD) ? scan_reg[VW-1:0] : vaddr;

    always_ff @(posedge clk)
    begin
        region_rd_reg <= region_mem[corner_reg[i_reg]];
        edge_rd_reg   <= edge_mem[edge_raddr];
        vtx_rd_reg    <= vtx_mem[vtx_raddr];
        if (cmd == mbv_pkg::C_CLR)
        begin
            region_mem[sweep_reg] <= 1'b0;
            vtx_mem[sweep_reg]    <= '0;
        end
        if (cmd == mbv_pkg::C_REGION && !range_bad)
        begin
            region_mem[corner_reg[0]] <= 1'b1;
        end
        if (cmd == mbv_pkg::C_VWR)
        begin
            vtx_mem[vaddr] <= vnew;
        end
        if (cmd == mbv_pkg::C_EDGE && !found_reg[i_reg])
        begin
            edge_mem[held_reg[EW-1:0]] <= {cur_key, 2'd1};
        end
        if (cmd == mbv_pkg::C_EDGE_CK && cnt < 2'd2)
        begin
            edge_mem[idx_reg[i_reg]] <= {edge_rd_reg[mbv_pkg::ENTRY_W-1:2], cnt + 2'd1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            used_reg   <= 1'b0;
            cursor_reg <= '0;
            sweep_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            case (cmd)
                mbv_pkg::C_CLR:
                begin
                    held_reg   <= '0;
                    used_reg   <= 1'b0;
                    cursor_reg <= '0;
                    sweep_reg  <= sweep_reg + 1'b1;
                end
                mbv_pkg::C_REGION:
                begin
                    cursor_reg <= '0;
                    if (!range_bad)
                    begin
                        used_reg <= 1'b1;
                    end
                end
                mbv_pkg::C_ELEM:
                begin
                    cursor_reg <= '0;
                end
                mbv_pkg::C_EDGE:
                begin
                    if (!found_reg[i_reg])
                    begin
                        held_reg <= held_reg + 1'b1;
                    end
                end
                mbv_pkg::C_SCAN_RD:
                begin
                    if (scan_reg >= UW'(mbv_pkg::NV) && !phase_reg)
                    begin
                        cursor_reg <= UW'(mbv_pkg::NV);
                    end
                end
                mbv_pkg::C_SCAN_CK:
                begin
                    if (!phase_reg && vtx_rd_reg != '0)
                    begin
                        cursor_reg <= scan_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (cmd == mbv_pkg::C_OUT)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            mbv_pkg::C_LOAD:
            begin
                op_reg     <= s_tuser;
                for (int k = 0; k < 4; k++)
                begin
                    corner_reg[k] <= s_tdata[k*VW +: VW];
                end
                res_st_reg <= mbv_pkg::ST_OK;
                res_v_reg  <= '0;
                res_f_reg  <= 1'b0;
                res_l_reg  <= 1'b0;
                i_reg      <= '0;
                vstep_reg  <= 1'b0;
                scan_reg   <= cursor_reg;
                phase_reg  <= 1'b0;
            end
            mbv_pkg::C_REGION:
            begin
                if (range_bad)
                begin
                    res_st_reg <= mbv_pkg::ST_RANGE;
                end
            end
            mbv_pkg::C_ELEM:
            begin
                i_reg <= '0;
                if (range_bad)
                begin
                    res_st_reg <= mbv_pkg::ST_RANGE;
                end
            end
            mbv_pkg::C_REG_CK:
            begin
                if (!region_rd_reg)
                begin
                    res_st_reg <= mbv_pkg::ST_OUTSIDE;
                end
                i_reg <= i_reg + 1'b1;
            end
            mbv_pkg::C_KEYS:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    key_reg[k] <= key_calc[k];
                end
                found_reg <= '0;
                ptr_reg   <= '0;
                rdv_reg   <= 1'b0;
            end
            mbv_pkg::C_SEARCH:
            begin
                rdv_reg <= ptr_reg < held_reg;
                rdi_reg <= ptr_reg[EW-1:0];
                if (ptr_reg < held_reg)
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
                if (rdv_reg)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        if (edge_rd_reg[mbv_pkg::ENTRY_W-1:2] == key_reg[k])
                        begin
                            found_reg[k] <= 1'b1;
                            idx_reg[k]   <= rdi_reg;
                        end
                    end
                end
            end
            mbv_pkg::C_NEED:
            begin
                i_reg     <= '0;
                vstep_reg <= 1'b0;
                if (table_full)
                begin
                    res_st_reg <= mbv_pkg::ST_FULL;
                end
            end
            mbv_pkg::C_EDGE:
            begin
                if (!found_reg[i_reg])
                begin
                    up_reg <= 1'b1;
                    for (int k = 0; k < 4; k++)
                    begin
                        if (2'(k) >= i_reg && key_reg[k] == cur_key)
                        begin
                            found_reg[k] <= 1'b1;
                            idx_reg[k]   <= held_reg[EW-1:0];
                        end
                    end
                end
            end
            mbv_pkg::C_EDGE_CK:
            begin
                up_reg <= (cnt == 2'd0);
                if (cnt >= 2'd2)
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            mbv_pkg::C_VWR:
            begin
                vstep_reg <= !vstep_reg;
                if (vstep_reg)
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            mbv_pkg::C_SCAN_RD:
            begin
                if (scan_reg >= UW'(mbv_pkg::NV))
                begin
                    if (phase_reg)
                    begin
                        res_l_reg <= 1'b1;
                    end
                    else
                    begin
                        res_st_reg <= mbv_pkg::ST_NO_MORE;
                    end
                end
            end
            mbv_pkg::C_SCAN_CK:
            begin
                if (vtx_rd_reg != '0)
                begin
                    if (!phase_reg)
                    begin
                        res_v_reg <= scan_reg[VW-1:0];
                        res_f_reg <= 1'b1;
                        phase_reg <= 1'b1;
                        scan_reg  <= scan_reg + 1'b1;
                    end
                    else
                    begin
                        res_l_reg <= 1'b0;
                    end
                end
                else
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            mbv_pkg::C_OUT:
            begin
                ost_reg    <= res_st_reg;
                overt_reg  <= res_v_reg;
                ofound_reg <= res_f_reg;
                olast_reg  <= res_l_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {ofound_reg, overt_reg, ost_reg};
    assign m_tlast  = olast_reg;

    always_comb
    begin
        st             = '0;
        st.op          = op_reg;
        st.clr_last    = &sweep_reg;
        st.range_bad   = range_bad;
        st.region_used = used_reg;
        st.region_hit  = region_rd_reg;
        st.last_corner = (i_reg == n_last);
        st.search_done = search_done;
        st.table_full  = table_full;
        st.key_found   = found_reg[i_reg];
        st.cnt_sat     = (cnt >= 2'd2);
        st.vstep       = vstep_reg;
        st.scan_end    = (scan_reg >= UW'(mbv_pkg::NV));
        st.scan_hit    = (vtx_rd_reg != '0);
        st.scan_phase  = phase_reg;
        st.out_free    = out_free;
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HW'(mbv_pkg::NE))
        else $error("edge table count past its size");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= UW'(mbv_pkg::NV))
        else $error("scan cursor past the vertex range");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && ofound_reg |-> ost_reg == mbv_pkg::ST_OK)
        else $error("vertex returned with a failing status");

    a_last_found: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && olast_reg |-> ofound_reg)
        else $error("last flag without a vertex");

endmodule

FILE: hw/rtl/mesh_boundary_vertex_finder_top.sv
// channel | dir | tdata (low bit up)                              | tuser | tlast
// s_*     | in  | corner_a[11:0] corner_b corner_c corner_d (48) | op    | -
// m_*     | out | status[2:0] boundary_vertex[14:3] found[15]     | -     | last
//
// clear and reset each sweep 4096 vertex entries, one a cycle
// element: optional region check, a search of all held edges, then per-edge updates
// next: a read and a check for each vertex counter visited from the scan cursor
// after reset no beat is taken until the clearing sweep of 4096 entries is over
// a finished result waits in the output register while the next beat is taken
module mesh_boundary_vertex_finder_top (
    input  logic                      clk,
    input  logic                      rst_n,
    // corner_a, corner_b, corner_c, corner_d
    input  logic [mbv_pkg::IN_W-1:0]  s_tdata,
    // op
    input  logic [2:0]                s_tuser,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // status, boundary_vertex, found
    output logic [mbv_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready
);

    // command from the sequencer, status back from the datapath
    mbv_pkg::cmd_t  cmd;
    mbv_pkg::stat_t st;

    mbv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .st       (st),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    // memories for region map, edge table and vertex counters live here
    mbv_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .st       (st)
    );

endmodule
